// ===== design/pdc_pkg.sv =====
// Shared types and constants of the preset arm PD controller.
package pdc_pkg;

  typedef enum logic [2:0] {
    CMD_KEEP      = 3'd0,
    CMD_PRESET    = 3'd1,
    CMD_CUSTOM    = 3'd2,
    CMD_STEP_UP   = 3'd3,
    CMD_STEP_DOWN = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_PRESET_0  = 3'd0,
    REG_PRESET_1  = 3'd1,
    REG_PRESET_2  = 3'd2,
    REG_PRESET_3  = 3'd3,
    REG_GAIN_P    = 3'd4,
    REG_GAIN_D    = 3'd5,
    REG_HOLD      = 3'd6,
    REG_STOP_BAND = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [3:0][15:0] preset_pos;
    logic [9:0]       gain_p;
    logic [9:0]       gain_d;
    logic [6:0]       hold_offset;
    logic [9:0]       stop_band;
  } cfg_t;

  localparam logic [15:0] PRESET_0_RESET   = 16'd0;
  localparam logic [15:0] PRESET_1_RESET   = 16'd550;
  localparam logic [15:0] PRESET_2_RESET   = 16'd5800;
  localparam logic [15:0] PRESET_3_RESET   = 16'd9650;
  localparam logic [9:0]  GAIN_P_RESET     = 10'd51;
  localparam logic [9:0]  GAIN_D_RESET     = 10'd205;
  localparam logic [6:0]  HOLD_RESET       = 7'd30;
  localparam logic [9:0]  STOP_BAND_RESET  = 10'd20;

  localparam logic [1:0]  LEVEL_MAX = 2'd3;
  localparam int          Q_SHIFT   = 8;
  localparam int          DRIVE_MAX = 127;

endpackage

// ===== design/pdc_cfg_regs.sv =====
// Configuration register file of the preset arm PD controller.
module pdc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output pdc_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preset_pos[0] <= pdc_pkg::PRESET_0_RESET;
      cfg.preset_pos[1] <= pdc_pkg::PRESET_1_RESET;
      cfg.preset_pos[2] <= pdc_pkg::PRESET_2_RESET;
      cfg.preset_pos[3] <= pdc_pkg::PRESET_3_RESET;
      cfg.gain_p        <= pdc_pkg::GAIN_P_RESET;
      cfg.gain_d        <= pdc_pkg::GAIN_D_RESET;
      cfg.hold_offset   <= pdc_pkg::HOLD_RESET;
      cfg.stop_band     <= pdc_pkg::STOP_BAND_RESET;
    end else if (cfg_we) begin
      case (pdc_pkg::reg_index_t'(cfg_index))
        pdc_pkg::REG_PRESET_0:  cfg.preset_pos[0] <= cfg_data;
        pdc_pkg::REG_PRESET_1:  cfg.preset_pos[1] <= cfg_data;
        pdc_pkg::REG_PRESET_2:  cfg.preset_pos[2] <= cfg_data;
        pdc_pkg::REG_PRESET_3:  cfg.preset_pos[3] <= cfg_data;
        pdc_pkg::REG_GAIN_P:    cfg.gain_p        <= cfg_data[9:0];
        pdc_pkg::REG_GAIN_D:    cfg.gain_d        <= cfg_data[9:0];
        pdc_pkg::REG_HOLD:      cfg.hold_offset   <= cfg_data[6:0];
        pdc_pkg::REG_STOP_BAND: cfg.stop_band     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pdc_target.sv =====
// Target and preset level tracking of the preset arm PD controller.
module pdc_target #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [2:0]                       command,
  input  logic [1:0]                       preset_index,
  input  logic [15:0]                      custom_position,
  input  pdc_pkg::cfg_t                    cfg,
  output logic signed [POSITION_WIDTH-1:0] target_next,
  output logic [1:0]                       level_next
);

  logic signed [POSITION_WIDTH-1:0] target_pos;
  logic [1:0]                       preset_level;
  logic signed [31:0]               preset_wide;
  logic signed [31:0]               custom_wide;

  assign preset_wide = 32'(signed'(cfg.preset_pos[level_next]));
  assign custom_wide = 32'(signed'(custom_position));

  always_comb begin
    level_next  = preset_level;
    target_next = target_pos;
    case (pdc_pkg::cmd_t'(command))
      pdc_pkg::CMD_PRESET: begin
        level_next  = preset_index;
        target_next = preset_wide[POSITION_WIDTH-1:0];
      end
      pdc_pkg::CMD_CUSTOM: begin
        target_next = custom_wide[POSITION_WIDTH-1:0];
      end
      pdc_pkg::CMD_STEP_UP: begin
        if (preset_level != pdc_pkg::LEVEL_MAX) begin
          level_next = preset_level + 2'd1;
        end
        target_next = preset_wide[POSITION_WIDTH-1:0];
      end
      pdc_pkg::CMD_STEP_DOWN: begin
        if (preset_level != 2'd0) begin
          level_next = preset_level - 2'd1;
        end
        target_next = preset_wide[POSITION_WIDTH-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pos   <= '0;
      preset_level <= '0;
    end else if (en) begin
      target_pos   <= target_next;
      preset_level <= level_next;
    end
  end

endmodule

// ===== design/pdc_law.sv =====
// PD control law with hold offset, clamp and stop band of the arm controller.
module pdc_law #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic signed [POSITION_WIDTH-1:0] target,
  input  logic [15:0]                      measured_position,
  input  pdc_pkg::cfg_t                    cfg,
  output logic [7:0]                       drive,
  output logic                             brake
);

  localparam int EW = POSITION_WIDTH + 1;
  localparam int DW = POSITION_WIDTH + 2;
  localparam int PW = EW + 11;
  localparam int RW = DW + 11;
  localparam int SW = POSITION_WIDTH + 16;
  localparam int QW = SW - pdc_pkg::Q_SHIFT;
  localparam int MW = (EW > 10) ? EW : 10;
  localparam logic signed [QW-1:0] QMAX = QW'(pdc_pkg::DRIVE_MAX);
  localparam logic signed [QW-1:0] QMIN = -QW'(pdc_pkg::DRIVE_MAX);

  logic signed [EW-1:0]             last_error;
  logic signed [31:0]               meas_wide;
  logic signed [POSITION_WIDTH-1:0] meas;
  logic signed [EW-1:0]             err;
  logic signed [DW-1:0]             deriv;
  logic signed [10:0]               gp;
  logic signed [10:0]               gd;
  logic signed [PW-1:0]             prod_p;
  logic signed [RW-1:0]             prod_d;
  logic signed [SW-1:0]             hold_term;
  logic signed [SW-1:0]             sum;
  logic signed [QW-1:0]             q_floor;
  logic signed [QW-1:0]             q;
  logic                             round_up;
  logic                             target_pos;
  logic [EW-1:0]                    mag;

  assign meas_wide = 32'(signed'(measured_position));
  assign meas      = meas_wide[POSITION_WIDTH-1:0];
  assign err       = EW'(target) - EW'(meas);
  assign deriv     = DW'(err) - DW'(last_error);
  assign gp        = signed'({1'b0, cfg.gain_p});
  assign gd        = signed'({1'b0, cfg.gain_d});
  assign prod_p    = err * gp;
  assign prod_d    = deriv * gd;

  assign target_pos = !target[POSITION_WIDTH-1] && (|target);
  assign hold_term  = target_pos ? SW'({cfg.hold_offset, 8'd0}) : '0;
  assign sum        = SW'(prod_p) + SW'(prod_d) + hold_term;

  // Division by 256 rounds toward zero: negative sums with a fraction move up by one.
  assign q_floor  = sum[SW-1:pdc_pkg::Q_SHIFT];
  assign round_up = sum[SW-1] && (|sum[pdc_pkg::Q_SHIFT-1:0]);
  assign q        = q_floor + QW'(round_up);

  assign mag   = err[EW-1] ? EW'(-err) : EW'(err);
  assign brake = MW'(mag) < MW'(cfg.stop_band);

  always_comb begin
    if (brake) begin
      drive = '0;
    end else if (q > QMAX) begin
      drive = QMAX[7:0];
    end else if (q < QMIN) begin
      drive = QMIN[7:0];
    end else begin
      drive = q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
    end else if (en) begin
      last_error <= err;
    end
  end

endmodule

// ===== design/preset_arm_pd_controller.sv =====
// Top level of the preset arm PD position controller.
//
// One control tick enters per transfer on the s_ channel: s_tuser carries the
// command and s_tdata the preset index, the custom position and the measured
// position. Each tick produces exactly one result transfer on the m_ channel
// carrying drive, brake, preset level and the target in force.
// A tick is held in an input register, the target update and the PD law run in
// one combinational pass, and the result lands in an output register, from which
// it transfers once the receiver takes it. While the receiver keeps up, one tick
// can be accepted every cycle; the state update for a tick completes in the same
// cycle that its result is registered, so consecutive ticks see each other.
// When the receiver stalls, the result waits in the output register and one
// further tick is still taken into the input register before s_tready drops.
// Reset clears both stages, the preset level, the target and the previous
// error, and loads the configuration registers with their default values.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, since the block itself does not enforce this.
module preset_arm_pd_controller #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] preset_index, [17:2] custom_position, [33:18] measured_position
  input  logic [39:0] s_tdata,
  // [2:0] command
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] drive, [8] brake, [10:9] level, [26:11] target_out
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pdc_pkg::cfg_t cfg;

  logic        in_valid;
  logic [2:0]  in_command;
  logic [1:0]  in_index;
  logic [15:0] in_custom;
  logic [15:0] in_measured;

  logic        advance;
  logic        fire;

  logic signed [POSITION_WIDTH-1:0] target_next;
  logic [1:0]                       level_next;
  logic [7:0]                       drive;
  logic                             brake;
  logic signed [31:0]               target_wide;

  logic [7:0]  out_drive;
  logic        out_brake;
  logic [1:0]  out_level;
  logic [15:0] out_target;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  pdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdc_target #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_target (
    .clk             (clk),
    .rst             (rst),
    .en              (fire),
    .command         (in_command),
    .preset_index    (in_index),
    .custom_position (in_custom),
    .cfg             (cfg),
    .target_next     (target_next),
    .level_next      (level_next)
  );

  pdc_law #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_law (
    .clk               (clk),
    .rst               (rst),
    .en                (fire),
    .target            (target_next),
    .measured_position (in_measured),
    .cfg               (cfg),
    .drive             (drive),
    .brake             (brake)
  );

  assign target_wide = 32'(target_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command  <= s_tuser;
      in_index    <= s_tdata[1:0];
      in_custom   <= s_tdata[17:2];
      in_measured <= s_tdata[33:18];
    end
    if (fire) begin
      out_drive  <= drive;
      out_brake  <= brake;
      out_level  <= level_next;
      out_target <= target_wide[15:0];
    end
  end

  assign m_tdata = {5'd0, out_target, out_level, out_brake, out_drive};

endmodule

// ===== tb/sv/preset_arm_pd_controller_test.sv =====
// Self-checking testbench for the preset arm PD position controller.
module preset_arm_pd_controller_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TICKS   = 100;
  localparam int PHASES         = 8;

  typedef struct packed {
    logic [4:0]         pad;
    logic signed [15:0] target_out;
    logic [1:0]         level;
    logic               brake;
    logic signed [7:0]  drive;
  } pd_result_t;

  class pd_scoreboard;
    logic signed [15:0] preset_pos[4];
    longint             gain_p;
    longint             gain_d;
    longint             hold;
    longint             band;
    longint             prev_err;
    logic [1:0]         level;
    logic signed [15:0] target;
    pd_result_t         due_results[$];
    int                 errors;

    function new();
      preset_pos[0] = pdc_pkg::PRESET_0_RESET;
      preset_pos[1] = pdc_pkg::PRESET_1_RESET;
      preset_pos[2] = pdc_pkg::PRESET_2_RESET;
      preset_pos[3] = pdc_pkg::PRESET_3_RESET;
      gain_p = pdc_pkg::GAIN_P_RESET;
      gain_d = pdc_pkg::GAIN_D_RESET;
      hold = pdc_pkg::HOLD_RESET;
      band = pdc_pkg::STOP_BAND_RESET;
      prev_err = 0;
      level = '0;
      target = '0;
      errors = 0;
    endfunction

    function void set_reg(pdc_pkg::reg_index_t idx, logic [15:0] v);
      case (idx)
        pdc_pkg::REG_PRESET_0, pdc_pkg::REG_PRESET_1,
        pdc_pkg::REG_PRESET_2, pdc_pkg::REG_PRESET_3: preset_pos[2'(idx)] = v;
        pdc_pkg::REG_GAIN_P:    gain_p = v[9:0];
        pdc_pkg::REG_GAIN_D:    gain_d = v[9:0];
        pdc_pkg::REG_HOLD:      hold = v[6:0];
        pdc_pkg::REG_STOP_BAND: band = v[9:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [2:0] cmd, logic [1:0] idx, logic [15:0] cpos,
                            logic [15:0] mpos);
      logic signed [15:0] meas;
      longint             err;
      longint             deriv;
      longint             sum;
      longint             drv;
      longint             mag;
      pd_result_t         want;
      meas = mpos;
      case (pdc_pkg::cmd_t'(cmd))
        pdc_pkg::CMD_PRESET: begin
          level = idx;
          target = preset_pos[level];
        end
        pdc_pkg::CMD_CUSTOM: target = cpos;
        pdc_pkg::CMD_STEP_UP: begin
          if (level != pdc_pkg::LEVEL_MAX) level = level + 2'd1;
          target = preset_pos[level];
        end
        pdc_pkg::CMD_STEP_DOWN: begin
          if (level != 2'd0) level = level - 2'd1;
          target = preset_pos[level];
        end
        default: ;
      endcase
      err = target;
      err = err - longint'(meas);
      deriv = err - prev_err;
      prev_err = err;
      sum = err * gain_p + deriv * gain_d;
      if (target > 0) sum += hold << pdc_pkg::Q_SHIFT;
      drv = sum / (longint'(1) << pdc_pkg::Q_SHIFT);
      if (drv > pdc_pkg::DRIVE_MAX) drv = pdc_pkg::DRIVE_MAX;
      if (drv < -pdc_pkg::DRIVE_MAX) drv = -pdc_pkg::DRIVE_MAX;
      mag = (err < 0) ? -err : err;
      want.brake = (mag < band);
      want.drive = want.brake ? 8'sd0 : drv[7:0];
      want.level = level;
      want.target_out = target;
      want.pad = '0;
      due_results.push_back(want);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [31:0] data);
      pd_result_t got;
      pd_result_t want;
      got = data;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      want = due_results.pop_front();
      compare_field("drive", want.drive, got.drive);
      compare_field("brake", want.brake, got.brake);
      compare_field("level", want.level, got.level);
      compare_field("target_out", want.target_out, got.target_out);
      compare_field("padding", want.pad, got.pad);
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = pdc_pkg::CMD_KEEP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = pdc_pkg::REG_PRESET_0;
  logic [15:0] cfg_data = '0;

  pd_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  int quiet_cycles = 0;

  preset_arm_pd_controller u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (rx_calm > 0) begin
      rx_calm--;
      m_tready <= 1'b1;
    end else if (rx_stall_pct > 0 && $urandom_range(63) == 0) begin
      rx_calm = $urandom_range(10, 40);
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("preset_arm_pd_controller regression: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic [2:0] cmd, input logic [1:0] idx,
                           input logic [15:0] cpos, input logic [15:0] mpos);
    int gap;
    gap = 0;
    if (tx_calm > 0) begin
      tx_calm--;
    end else if (tx_idle_pct > 0 && $urandom_range(49) == 0) begin
      tx_calm = $urandom_range(5, 25);
    end else begin
      while ($urandom_range(99) < tx_idle_pct) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {6'b0, mpos, cpos, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(cmd, idx, cpos, mpos);
  endtask

  task automatic random_tick();
    logic [2:0]  cmd;
    logic [1:0]  idx;
    logic [15:0] cpos;
    logic [15:0] base;
    int          r;
    int          span;
    r = $urandom_range(99);
    idx = 2'($urandom);
    cpos = 16'($urandom);
    if (r < 25) cmd = pdc_pkg::CMD_KEEP;
    else if (r < 45) cmd = pdc_pkg::CMD_PRESET;
    else if (r < 60) cmd = pdc_pkg::CMD_CUSTOM;
    else if (r < 75) cmd = pdc_pkg::CMD_STEP_UP;
    else if (r < 90) cmd = pdc_pkg::CMD_STEP_DOWN;
    else cmd = 3'($urandom);
    if (cmd == pdc_pkg::CMD_CUSTOM) base = cpos;
    else if (cmd == pdc_pkg::CMD_PRESET) base = sb.preset_pos[idx];
    else base = sb.target;
    span = $urandom_range(1) ? 48 : 700;
    if ($urandom_range(3) == 0) send_tick(cmd, idx, cpos, 16'($urandom));
    else send_tick(cmd, idx, cpos, base + 16'($urandom_range(2 * span)) - 16'(span));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input pdc_pkg::reg_index_t idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(input int sel);
    case (sel)
      0: begin
        write_reg(pdc_pkg::REG_PRESET_0, 16'h8000);
        write_reg(pdc_pkg::REG_PRESET_1, 16'h7fff);
        write_reg(pdc_pkg::REG_PRESET_2, 16'h0000);
        write_reg(pdc_pkg::REG_PRESET_3, 16'hffff);
        write_reg(pdc_pkg::REG_GAIN_P, 16'd1023);
        write_reg(pdc_pkg::REG_GAIN_D, 16'd1023);
        write_reg(pdc_pkg::REG_HOLD, 16'd127);
        write_reg(pdc_pkg::REG_STOP_BAND, 16'd0);
      end
      1: begin
        write_reg(pdc_pkg::REG_PRESET_0, 16'h7fff);
        write_reg(pdc_pkg::REG_PRESET_1, 16'h8000);
        write_reg(pdc_pkg::REG_PRESET_2, 16'h0001);
        write_reg(pdc_pkg::REG_PRESET_3, 16'h0000);
        write_reg(pdc_pkg::REG_GAIN_P, 16'd0);
        write_reg(pdc_pkg::REG_GAIN_D, 16'd0);
        write_reg(pdc_pkg::REG_HOLD, 16'd0);
        write_reg(pdc_pkg::REG_STOP_BAND, 16'd1023);
      end
      2: begin
        write_reg(pdc_pkg::REG_PRESET_0, pdc_pkg::PRESET_0_RESET);
        write_reg(pdc_pkg::REG_PRESET_1, pdc_pkg::PRESET_1_RESET);
        write_reg(pdc_pkg::REG_PRESET_2, pdc_pkg::PRESET_2_RESET);
        write_reg(pdc_pkg::REG_PRESET_3, pdc_pkg::PRESET_3_RESET);
        write_reg(pdc_pkg::REG_GAIN_P, 16'(pdc_pkg::GAIN_P_RESET));
        write_reg(pdc_pkg::REG_GAIN_D, 16'(pdc_pkg::GAIN_D_RESET));
        write_reg(pdc_pkg::REG_HOLD, 16'(pdc_pkg::HOLD_RESET));
        write_reg(pdc_pkg::REG_STOP_BAND, 16'(pdc_pkg::STOP_BAND_RESET));
      end
      default: begin
        write_reg(pdc_pkg::REG_PRESET_0, 16'($urandom));
        write_reg(pdc_pkg::REG_PRESET_1, 16'($urandom));
        write_reg(pdc_pkg::REG_PRESET_2, 16'($urandom));
        write_reg(pdc_pkg::REG_PRESET_3, 16'($urandom));
        write_reg(pdc_pkg::REG_GAIN_P, 16'($urandom_range(1023)));
        write_reg(pdc_pkg::REG_GAIN_D, 16'($urandom_range(1023)));
        write_reg(pdc_pkg::REG_HOLD, 16'($urandom_range(127)));
        write_reg(pdc_pkg::REG_STOP_BAND, 16'($urandom_range(1) ? $urandom_range(60)
                                                                : $urandom_range(1023)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_tick(pdc_pkg::CMD_KEEP, 2'd0, 16'h0000, 16'd0);
    send_tick(pdc_pkg::CMD_KEEP, 2'd3, 16'hffff, 16'd19);
    send_tick(pdc_pkg::CMD_KEEP, 2'd0, 16'h0000, -16'sd20);
    send_tick(pdc_pkg::CMD_KEEP, 2'd0, 16'h0000, 16'd20);
    send_tick(pdc_pkg::CMD_PRESET, 2'd1, 16'h0000, 16'd0);
    send_tick(pdc_pkg::CMD_PRESET, 2'd2, 16'h5555, 16'd5800);
    send_tick(pdc_pkg::CMD_PRESET, 2'd3, 16'haaaa, 16'h8000);
    send_tick(pdc_pkg::CMD_STEP_UP, 2'd0, 16'h0000, 16'h7fff);
    send_tick(pdc_pkg::CMD_STEP_DOWN, 2'd0, 16'h0000, 16'd5790);
    send_tick(pdc_pkg::CMD_STEP_DOWN, 2'd0, 16'h0000, 16'd600);
    send_tick(pdc_pkg::CMD_STEP_DOWN, 2'd0, 16'h0000, 16'd0);
    send_tick(pdc_pkg::CMD_STEP_DOWN, 2'd0, 16'h0000, 16'd5);
    send_tick(pdc_pkg::CMD_STEP_UP, 2'd0, 16'h0000, 16'd540);
    send_tick(pdc_pkg::CMD_CUSTOM, 2'd0, 16'h7fff, 16'h8000);
    send_tick(pdc_pkg::CMD_CUSTOM, 2'd0, 16'h8000, 16'h7fff);
    send_tick(pdc_pkg::CMD_CUSTOM, 2'd0, 16'h8000, 16'h8000);
    send_tick(pdc_pkg::CMD_STEP_DOWN + 3'd1, 2'd1, 16'h1234, -16'sd32700);
    send_tick(pdc_pkg::CMD_STEP_DOWN + 3'd2, 2'd2, 16'h4321, 16'd100);
    send_tick(pdc_pkg::CMD_STEP_DOWN + 3'd3, 2'd3, 16'hffff, -16'sd32768);
    send_tick(pdc_pkg::CMD_PRESET, 2'd0, 16'h0000, -16'sd100);
    send_tick(pdc_pkg::CMD_CUSTOM, 2'd0, 16'hffff, 16'd0);
    send_tick(pdc_pkg::CMD_CUSTOM, 2'd0, 16'h0001, 16'd300);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(p);
      tx_idle_pct = (p % 4 == 1) ? 88 : (p % 4 == 3) ? 10 : 0;
      rx_stall_pct = (p % 4 == 2) ? 88 : (p % 4 == 3) ? 10 : 0;
      repeat (RANDOM_TICKS) random_tick();
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("preset_arm_pd_controller regression: pass");
    end else begin
      $display("preset_arm_pd_controller regression: fail");
    end
    $finish;
  end

endmodule
